FILE: rtl/uwe_pkg.sv
// Shared constants, types and helpers for the unique word extractor.
package uwe_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int WORD_BYTES = 16;
    localparam int LINE_SIZE  = 256;

    localparam int WORD_W = WORD_BYTES * 8;
    localparam int SLOT_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int LEN_W  = $clog2(WORD_BYTES);
    localparam int LINE_W = $clog2(LINE_SIZE + 2);

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_LINE_LONG = 3'd1;
    localparam logic [2:0] ERR_WORD_LONG = 3'd2;
    localparam logic [2:0] ERR_NO_WORDS  = 3'd3;
    localparam logic [2:0] ERR_FULL      = 3'd4;

    localparam logic [7:0] CHAR_NL  = 8'd10;
    localparam logic [7:0] CHAR_NUL = 8'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd44) || (c == 8'd59) || (c == 8'd58) ||
               (c == 8'd45) || (c == 8'd46) || (c == 8'd33) || (c == 8'd63);
    endfunction

endpackage

FILE: rtl/unique_word_extractor.sv
// Top level: word splitter with a persistent table of distinct words in one RAM.
// A byte that completes no word goes straight to the output register; a completing
// byte first runs a table scan (one stored word compared per cycle, stopping early
// on a match) and then loads its result into the output register.
// A new byte is taken only once the result of the last one has been loaded; a result
// still waiting in the output register holds the next byte off.
// Reset (aresetn low, synchronous) clears control state and counts; the word
// table RAM is not cleared, since only slots below word_count are ever read.
module unique_word_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_word_ended,
    output logic       m_word_was_new,
    output logic [5:0] m_word_slot,
    output logic [6:0] m_word_total,
    output logic       m_line_done
);

    localparam int WW = uwe_pkg::WORD_W;
    localparam int SW = uwe_pkg::SLOT_W;
    localparam int CW = uwe_pkg::CNT_W;
    localparam int LW = uwe_pkg::LEN_W;
    localparam int NW = uwe_pkg::LINE_W;

    uwe_pkg::state_t state_reg, state_next;

    // line and table control state
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] start_reg, start_next;
    logic [WW-1:0] cur_reg, cur_next;
    logic [LW-1:0] len_reg, len_next;
    logic [NW-1:0] line_len_reg, line_len_next;
    logic          saw_reg, saw_next;
    logic [2:0]    err_reg, err_next;
    logic          eol_reg, eol_next;

    // result of the current byte
    logic          ended_reg, ended_next;
    logic          fresh_reg, fresh_next;
    logic [SW-1:0] slot_reg, slot_next;

    // scan pipeline
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [SW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic [WW-1:0] rd_data_reg;
    logic          rd_en;
    logic          wr_en;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic          m_ended_reg, m_ended_next;
    logic          m_fresh_reg, m_fresh_next;
    logic [5:0]    m_slot_reg, m_slot_next;
    logic [6:0]    m_total_reg, m_total_next;
    logic          m_done_reg, m_done_next;

    logic [WW-1:0] table_mem [uwe_pkg::MAX_WORDS];

    // byte step results
    logic          accept;
    logic          step_close;
    logic [2:0]    step_err;
    logic [CW-1:0] step_count;
    logic [WW-1:0] step_cur;
    logic [LW-1:0] step_len;
    logic [NW-1:0] step_line_len;
    logic          step_saw;

    logic          hit;
    logic          more;
    logic          emit_load;

    assign s_ready   = (state_reg == uwe_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign hit       = cmp_valid_reg && (rd_data_reg == cur_reg);
    assign more      = scan_idx_reg < count_reg;
    assign rd_en     = (state_reg == uwe_pkg::S_SCAN) && more && !hit;
    assign wr_en     = (state_reg == uwe_pkg::S_SCAN) && !hit && !more &&
                       (count_reg < CW'(uwe_pkg::MAX_WORDS));
    assign emit_load = (state_reg == uwe_pkg::S_EMIT) && (!m_valid_reg || m_ready);

    // process one byte of the line
    always_comb begin
        step_close    = 1'b0;
        step_err      = err_reg;
        step_count    = count_reg;
        step_cur      = cur_reg;
        step_len      = len_reg;
        step_line_len = line_len_reg;
        step_saw      = saw_reg;
        if (err_reg == uwe_pkg::ERR_OK) begin
            step_line_len = line_len_reg + NW'(1);
            if (step_line_len > NW'(uwe_pkg::LINE_SIZE)) begin
                step_err   = uwe_pkg::ERR_LINE_LONG;
                step_count = start_reg;
            end else if (s_char_code == uwe_pkg::CHAR_NL ||
                         s_char_code == uwe_pkg::CHAR_NUL) begin
                step_close = 1'b0;
            end else if (uwe_pkg::is_delim(s_char_code)) begin
                step_close = (len_reg != '0);
            end else begin
                step_saw = 1'b1;
                if (32'(len_reg) >= uwe_pkg::WORD_BYTES - 1) begin
                    step_err = uwe_pkg::ERR_WORD_LONG;
                end else begin
                    step_cur[len_reg*8 +: 8] = s_char_code;
                    step_len = len_reg + LW'(1);
                end
            end
            if (step_err == uwe_pkg::ERR_OK && s_end_of_line && step_len != '0) begin
                step_close = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            uwe_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = step_close ? uwe_pkg::S_SCAN : uwe_pkg::S_EMIT;
                end
            end
            uwe_pkg::S_SCAN: begin
                if (hit || !more) begin
                    state_next = uwe_pkg::S_EMIT;
                end
            end
            uwe_pkg::S_EMIT: begin
                if (emit_load) begin
                    state_next = uwe_pkg::S_IDLE;
                end
            end
            default: state_next = uwe_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next    = count_reg;
        start_next    = start_reg;
        cur_next      = cur_reg;
        len_next      = len_reg;
        line_len_next = line_len_reg;
        saw_next      = saw_reg;
        err_next      = err_reg;
        eol_next      = eol_reg;
        ended_next    = ended_reg;
        fresh_next    = fresh_reg;
        slot_next     = slot_reg;
        scan_idx_next = scan_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_ended_next  = m_ended_reg;
        m_fresh_next  = m_fresh_reg;
        m_slot_next   = m_slot_reg;
        m_total_next  = m_total_reg;
        m_done_next   = m_done_reg;
        unique case (state_reg)
            uwe_pkg::S_IDLE: begin
                if (accept) begin
                    count_next    = step_count;
                    cur_next      = step_cur;
                    len_next      = step_len;
                    line_len_next = step_line_len;
                    saw_next      = step_saw;
                    err_next      = step_err;
                    eol_next      = s_end_of_line;
                    ended_next    = 1'b0;
                    fresh_next    = 1'b0;
                    slot_next     = '0;
                    scan_idx_next = '0;
                end
            end
            uwe_pkg::S_SCAN: begin
                if (rd_en) begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit) begin
                    ended_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                end else if (!more) begin
                    if (wr_en) begin
                        ended_next = 1'b1;
                        fresh_next = 1'b1;
                        slot_next  = SW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end else begin
                        err_next = uwe_pkg::ERR_FULL;
                    end
                end
                // drop the completed word
                if (hit || !more) begin
                    cur_next = '0;
                    len_next = '0;
                end
            end
            uwe_pkg::S_EMIT: begin
                if (emit_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = (err_reg == uwe_pkg::ERR_OK && eol_reg && !saw_reg) ?
                                    uwe_pkg::ERR_NO_WORDS : err_reg;
                    m_ended_next  = ended_reg;
                    m_fresh_next  = fresh_reg;
                    m_slot_next   = 6'(slot_reg);
                    m_total_next  = 7'(count_reg);
                    m_done_next   = eol_reg;
                    // clear line state at the end of the line
                    if (eol_reg) begin
                        cur_next      = '0;
                        len_next      = '0;
                        line_len_next = '0;
                        saw_next      = 1'b0;
                        err_next      = uwe_pkg::ERR_OK;
                        start_next    = count_reg;
                    end
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= uwe_pkg::S_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            cur_reg       <= '0;
            len_reg       <= '0;
            line_len_reg  <= '0;
            saw_reg       <= 1'b0;
            err_reg       <= uwe_pkg::ERR_OK;
            eol_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            line_len_reg  <= line_len_next;
            saw_reg       <= saw_next;
            err_reg       <= err_next;
            eol_reg       <= eol_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= rd_en;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ended_reg    <= ended_next;
        fresh_reg    <= fresh_next;
        slot_reg     <= slot_next;
        cmp_idx_reg  <= scan_idx_reg[SW-1:0];
        m_status_reg <= m_status_next;
        m_ended_reg  <= m_ended_next;
        m_fresh_reg  <= m_fresh_next;
        m_slot_reg   <= m_slot_next;
        m_total_reg  <= m_total_next;
        m_done_reg   <= m_done_next;
    end

    // word table: one read, one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[count_reg[SW-1:0]] <= cur_reg;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[scan_idx_reg[SW-1:0]];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_word_ended   = m_ended_reg;
    assign m_word_was_new = m_fresh_reg;
    assign m_word_slot    = m_slot_reg;
    assign m_word_total   = m_total_reg;
    assign m_line_done    = m_done_reg;

    // table never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(uwe_pkg::MAX_WORDS))
        else $error("word count exceeds table capacity");

    // a new word is always reported as a completed word
    a_new_is_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_was_new |-> m_word_ended)
        else $error("new word without word end");

    // a match only comes from a slot below the word count
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uwe_pkg::S_SCAN) && hit |-> CW'(cmp_idx_reg) < count_reg)
        else $error("match on an unused slot");

    // a table write happens only while scanning ends without a match
    a_write_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (state_reg == uwe_pkg::S_EMIT) && ended_reg && fresh_reg)
        else $error("table write without new word result");

endmodule
